FILE: hdl/dss_pkg.sv
// Shared types and constants of the delimiter stream splitter.
// No dependencies; every other file but dss_in_if imports this package.
`default_nettype none

package dss_pkg;

    localparam int SEG_W     = 32;  // width of every reported segment field
    localparam int LEN_W     = 5;   // width of the pattern length register
    localparam int PAT_W     = 64;  // width of each pattern word register
    localparam int CFG_IDX_W = 2;   // width of the register index
    localparam int RES_DEPTH = 4;   // result queue entries
    localparam int RES_PTR_W = 2;   // address bits of the result queue
    localparam int RES_CNT_W = 3;   // fill count bits of the result queue

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SEG_W-1:0] segment_index;
        logic [SEG_W-1:0] segment_start;
        logic [SEG_W-1:0] segment_length;
        logic             final_segment;
    } t_seg;

    // Up to two results produced by one input beat, packed from the front.
    typedef struct packed {
        logic [1:0] count;
        t_seg       first;
        t_seg       second;
    } t_push;

endpackage

`default_nettype wire

FILE: hdl/dss_in_if.sv
// Input byte channel of the delimiter stream splitter.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface dss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/dss_out_if.sv
// Result channel of the delimiter stream splitter, one segment per beat.
// Depends on dss_pkg for the field widths.
`default_nettype none

interface dss_out_if import dss_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segment_index;
    logic [SEG_W-1:0] segment_start;
    logic [SEG_W-1:0] segment_length;
    logic             final_segment;

    modport source (output valid, output segment_index, output segment_start,
                    output segment_length, output final_segment, input ready);
    modport sink   (input valid, input segment_index, input segment_start,
                    input segment_length, input final_segment, output ready);
endinterface

`default_nettype wire

FILE: hdl/dss_cfg_if.sv
// Register write channel of the delimiter stream splitter.
// Depends on dss_pkg for the index and data widths.
`default_nettype none

interface dss_cfg_if import dss_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PAT_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dss_core.sv
// Byte window, parallel delimiter compare and segment bookkeeping.
// Depends on dss_pkg; emits up to two results per accepted beat.
`default_nettype none

module dss_core import dss_pkg::*; #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    input  wire logic [LEN_W-1:0]   i_pattern_length,
    input  wire logic [2*PAT_W-1:0] i_pattern,
    output t_push                   o_push
);

    logic [7:0]             r_win [MAX_PATTERN];
    logic [7:0]             n_win [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [SEG_W-1:0]       r_count, n_count;

    logic [LEN_W-1:0]       eff_len;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] match_start;
    logic [OFFSET_BITS-1:0] start_after;
    logic [SEG_W-1:0]       count_after;
    logic                   hit;
    logic                   cut;
    t_seg                   cut_seg;
    t_seg                   fin_seg;

    always_comb begin
        logic [LEN_W-1:0] idx;
        logic [7:0]       pbyte;

        if (i_pattern_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_pattern_length > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = i_pattern_length;
        end

        n_win[0] = i_data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end

        pos_inc = (r_pos != '1) ? r_pos + OFFSET_BITS'(1) : r_pos;

        // Window entry k (newest first) lines up with pattern byte len-1-k.
        hit = (pos_inc >= OFFSET_BITS'(eff_len));
        for (int k = 0; k < MAX_PATTERN; k++) begin
            idx   = eff_len - LEN_W'(k) - LEN_W'(1);
            pbyte = i_pattern[{idx[3:0], 3'b000} +: 8];
            if ((LEN_W'(k) < eff_len) && (n_win[k] != pbyte)) begin
                hit = 1'b0;
            end
        end

        match_start = pos_inc - OFFSET_BITS'(eff_len);
        cut         = hit && (match_start > r_start);
        start_after = cut ? match_start : r_start;
        count_after = (cut && (r_count != '1)) ? r_count + SEG_W'(1) : r_count;

        cut_seg.segment_index  = r_count;
        cut_seg.segment_start  = SEG_W'(r_start);
        cut_seg.segment_length = SEG_W'(match_start - r_start);
        cut_seg.final_segment  = 1'b0;

        fin_seg.segment_index  = count_after;
        fin_seg.segment_start  = SEG_W'(start_after);
        fin_seg.segment_length = SEG_W'(pos_inc - start_after);
        fin_seg.final_segment  = 1'b1;

        o_push.count  = i_accept ? (2'(cut) + 2'(i_last_byte)) : 2'd0;
        o_push.first  = cut ? cut_seg : fin_seg;
        o_push.second = fin_seg;

        if (i_last_byte) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                n_win[k] = 8'h00;
            end
            n_pos   = '0;
            n_start = '0;
            n_count = '0;
        end else begin
            n_pos   = pos_inc;
            n_start = start_after;
            n_count = count_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= 8'h00;
            end
            r_pos   <= '0;
            r_start <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_win   <= n_win;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dss_res_fifo.sv
// Result queue: takes up to two segments per cycle, delivers one per beat.
// Depends on dss_pkg for the segment and push types.
`default_nettype none

module dss_res_fifo import dss_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_space,
    output logic       o_valid,
    output t_seg       o_head
);

    t_seg                 r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wp, n_wp;
    logic [RES_PTR_W-1:0] r_rp, n_rp;
    logic [RES_CNT_W-1:0] r_count, n_count;
    logic                 pop;
    logic [RES_PTR_W-1:0] wp_next;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    // Room for a full pair of results is needed before a beat is taken.
    assign o_space = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign pop     = i_pop && o_valid;
    assign wp_next = r_wp + RES_PTR_W'(1);

    always_comb begin
        n_wp    = r_wp + RES_PTR_W'(i_push.count);
        n_rp    = pop ? r_rp + RES_PTR_W'(1) : r_rp;
        n_count = r_count + RES_CNT_W'(i_push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue holds more entries than it has");

    a_pair_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2) |-> (r_count <= RES_CNT_W'(RES_DEPTH - 2)))
        else $error("two results pushed without room for both");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count == $past(r_count) + RES_CNT_W'($past(i_push.count))
                                - RES_CNT_W'($past(pop))))
        else $error("result queue fill count lost track of pushes and pops");

endmodule

`default_nettype wire

FILE: hdl/delimiter_stream_splitter.sv
// Delimiter stream splitter: one byte per cycle in, one segment per beat out.
// A segment is registered in the result queue when its closing byte is accepted.
// Throughput: one byte per cycle while the four-entry result queue has room
// for two results; a byte that both cuts and ends the stream queues two.
// Reset (synchronous, active low) clears the window, offsets and count, and
// sets the pattern length to 1 and both pattern words to zero.
`default_nettype none

module delimiter_stream_splitter import dss_pkg::*; #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dss_in_if.sink    i_in,
    dss_out_if.source o_out,
    dss_cfg_if.sink   i_cfg
);

    logic [LEN_W-1:0] r_pattern_length;
    logic [PAT_W-1:0] r_pattern_low;
    logic [PAT_W-1:0] r_pattern_high;
    logic             in_accept;
    logic             space;
    t_push            push;
    t_seg             head;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = space;
    assign in_accept   = i_in.valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= LEN_W'(1);
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg.data[LEN_W-1:0];
                REG_PATTERN_LOW:    r_pattern_low    <= i_cfg.data;
                REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    dss_core #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_in.data_byte),
        .i_last_byte      (i_in.last_byte),
        .i_pattern_length (r_pattern_length),
        .i_pattern        ({r_pattern_high, r_pattern_low}),
        .o_push           (push)
    );

    dss_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_space (space),
        .o_valid (o_out.valid),
        .o_head  (head)
    );

    assign o_out.segment_index  = head.segment_index;
    assign o_out.segment_start  = head.segment_start;
    assign o_out.segment_length = head.segment_length;
    assign o_out.final_segment  = head.final_segment;

endmodule

`default_nettype wire
